// File: sv/rle_bilevel_to_ascii_density_top_assert.svh
// assertion macros for the rle bilevel to ascii density block
// no dependencies; included by the top level only
`ifndef RLE_BILEVEL_TO_ASCII_DENSITY_TOP_ASSERT_SVH
`define RLE_BILEVEL_TO_ASCII_DENSITY_TOP_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define RBAD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbad assertion failed");

// next-cycle implication under synchronous active-low reset
`define RBAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbad assertion failed");

`endif

// File: sv/rbad_pkg.sv
// shared types, constants and helper functions for the rle bilevel density block
// no dependencies
package rbad_pkg;

  localparam int FRAME_WIDTH_DEF  = 120;
  localparam int FRAME_HEIGHT_DEF = 68;
  localparam int CELL_WIDTH_DEF   = 3;
  localparam int CELL_HEIGHT_DEF  = 4;
  localparam int CELL_COLUMNS_DEF = 40;
  localparam int CELL_ROWS_DEF    = 16;

  // cap on result words produced by one run word
  localparam int MAX_RESULTS = 40;
  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  // widest cell count that density_of takes (8x8 cell)
  localparam int COUNT_MAX_W = 7;
  localparam int DENSITY_MAX = 9;

  typedef struct packed {
    logic [7:0] run_length;
    logic       start_of_frame;
  } in_word_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic [3:0] density;
    logic [5:0] cell_column;
    logic [3:0] cell_row;
    logic       last_of_band;
  } out_word_t;

  // classified run handed from front to back
  typedef struct packed {
    logic [7:0] run_length;
    logic       start_of_frame;
    logic       zero_run;
  } cmd_t;

  // count * 9 / 12 == count * 3 / 4, saturated
  function automatic logic [3:0] density_of(input logic [COUNT_MAX_W-1:0] count);
    logic [COUNT_MAX_W+1:0] scaled;
    logic [COUNT_MAX_W-1:0] d;
    scaled = (COUNT_MAX_W+2)'(count) * (COUNT_MAX_W+2)'(3);
    d      = scaled[COUNT_MAX_W+1:2];
    if (d > COUNT_MAX_W'(DENSITY_MAX)) begin
      d = COUNT_MAX_W'(DENSITY_MAX);
    end
    return d[3:0];
  endfunction

  // density ramp " .:-=+*#%@"
  function automatic logic [6:0] char_of(input logic [3:0] d);
    logic [6:0] c;
    unique case (d)
      4'd0:    c = 7'h20;
      4'd1:    c = 7'h2E;
      4'd2:    c = 7'h3A;
      4'd3:    c = 7'h2D;
      4'd4:    c = 7'h3D;
      4'd5:    c = 7'h2B;
      4'd6:    c = 7'h2A;
      4'd7:    c = 7'h23;
      4'd8:    c = 7'h25;
      4'd9:    c = 7'h40;
      default: c = 7'h20;
    endcase
    return c;
  endfunction

endpackage

// File: sv/rbad_front.sv
// front end: accepts run words, tags zero runs, queues them for the back end
// depends on rbad_pkg
module rbad_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rbad_pkg::in_word_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output rbad_pkg::cmd_t    cmd
);

  localparam int PTR_W = (rbad_pkg::QUEUE_DEPTH > 1) ? $clog2(rbad_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rbad_pkg::QUEUE_DEPTH + 1);

  rbad_pkg::cmd_t   q_mem_r [rbad_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;
  rbad_pkg::cmd_t   new_cmd;

  assign in_ready  = (cnt_r != CNT_W'(rbad_pkg::QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    new_cmd.run_length     = in_data.run_length;
    new_cmd.start_of_frame = in_data.start_of_frame;
    new_cmd.zero_run       = (in_data.run_length == 8'd0);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(rbad_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(rbad_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// File: sv/rbad_back.sv
// back end: expands runs a row segment at a time, counts cells, emits bands
// depends on rbad_pkg
module rbad_back #(
  parameter int FRAME_WIDTH  = rbad_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rbad_pkg::FRAME_HEIGHT_DEF,
  parameter int CELL_WIDTH   = rbad_pkg::CELL_WIDTH_DEF,
  parameter int CELL_HEIGHT  = rbad_pkg::CELL_HEIGHT_DEF,
  parameter int CELL_COLUMNS = rbad_pkg::CELL_COLUMNS_DEF,
  parameter int CELL_ROWS    = rbad_pkg::CELL_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  rbad_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output rbad_pkg::out_word_t out_data
);

  localparam int COL_W  = $clog2(FRAME_WIDTH + 1);
  localparam int ROW_W  = $clog2(FRAME_HEIGHT + 1);
  localparam int SUB_W  = (CELL_HEIGHT > 1) ? $clog2(CELL_HEIGHT) : 1;
  localparam int IDX_W  = (CELL_COLUMNS > 1) ? $clog2(CELL_COLUMNS) : 1;
  localparam int CNT_W  = $clog2(CELL_WIDTH * CELL_HEIGHT + 1);
  localparam int SENT_W = $clog2(rbad_pkg::MAX_RESULTS + 1);
  localparam int SPAN_A = (COL_W > 8) ? COL_W + 1 : 9;
  localparam int SPAN_B = $clog2(CELL_COLUMNS * CELL_WIDTH + 1) + 1;
  localparam int SPAN_W = (SPAN_A > SPAN_B) ? SPAN_A : SPAN_B;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SUB_W-1:0]  sub_r, sub_nxt;
  logic [ROW_W-1:0]  band_r, band_nxt;
  logic              colour_r, colour_nxt;
  logic              done_r, done_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]  counts_r [CELL_COLUMNS];
  logic [CNT_W-1:0]  counts_nxt [CELL_COLUMNS];
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [ROW_W-1:0]  emit_band_r, emit_band_nxt;
  logic [SENT_W-1:0] sent_r, sent_nxt;
  logic              out_valid_r, out_valid_nxt;
  rbad_pkg::out_word_t out_data_r, out_data_nxt;

  logic [SPAN_W-1:0] to_end, rem_ext, seg, seg_end;
  logic [SPAN_W-1:0] lo, hi, a, b, ov;
  logic              counting, capped, load_out, finish;
  logic              colour_v, done_v;
  logic [3:0]        dens;
  logic [15:0]       idx_ext, band_ext;

  assign cmd_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    sub_nxt       = sub_r;
    band_nxt      = band_r;
    colour_nxt    = colour_r;
    done_nxt      = done_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    emit_band_nxt = emit_band_r;
    sent_nxt      = sent_r;
    out_data_nxt  = out_data_r;
    load_out      = 1'b0;
    finish        = 1'b0;
    colour_v      = colour_r;
    done_v        = done_r;
    lo            = '0;
    hi            = '0;
    a             = '0;
    b             = '0;
    ov            = '0;
    for (int k = 0; k < CELL_COLUMNS; k++) begin
      counts_nxt[k] = counts_r[k];
    end

    // row segment of the current run
    to_end   = SPAN_W'(FRAME_WIDTH) - SPAN_W'(col_r);
    rem_ext  = SPAN_W'(rem_r);
    seg      = (rem_ext < to_end) ? rem_ext : to_end;
    seg_end  = SPAN_W'(col_r) + seg;
    counting = colour_r && (32'(band_r) < 32'(CELL_ROWS));
    capped   = (sent_r >= SENT_W'(rbad_pkg::MAX_RESULTS));
    dens     = rbad_pkg::density_of(rbad_pkg::COUNT_MAX_W'(counts_r[0]));
    idx_ext  = 16'(idx_r);
    band_ext = 16'(emit_band_r);

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.start_of_frame) begin
            col_nxt  = '0;
            row_nxt  = '0;
            sub_nxt  = '0;
            band_nxt = '0;
            colour_v = 1'b0;
            done_v   = 1'b0;
            for (int k = 0; k < CELL_COLUMNS; k++) begin
              counts_nxt[k] = '0;
            end
          end
          done_nxt   = done_v;
          colour_nxt = colour_v;
          if (!done_v) begin
            if (cmd.zero_run) begin
              colour_nxt = ~colour_v;
            end else begin
              rem_nxt   = cmd.run_length;
              sent_nxt  = '0;
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (counting) begin
          for (int k = 0; k < CELL_COLUMNS; k++) begin
            lo = SPAN_W'(k * CELL_WIDTH);
            hi = SPAN_W'((k + 1) * CELL_WIDTH);
            a  = (SPAN_W'(col_r) > lo) ? SPAN_W'(col_r) : lo;
            b  = (seg_end < hi) ? seg_end : hi;
            ov = (b > a) ? b - a : '0;
            counts_nxt[k] = counts_r[k] + CNT_W'(ov);
          end
        end
        rem_nxt = rem_r - 8'(seg);
        if (seg_end == SPAN_W'(FRAME_WIDTH)) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
          if (row_r + 1'b1 >= ROW_W'(FRAME_HEIGHT)) begin
            done_nxt = 1'b1;
          end
          if (sub_r == SUB_W'(CELL_HEIGHT - 1)) begin
            sub_nxt  = '0;
            band_nxt = band_r + 1'b1;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end else begin
          col_nxt = COL_W'(seg_end);
        end
        if (seg_end == SPAN_W'(FRAME_WIDTH) && sub_r == SUB_W'(CELL_HEIGHT - 1) &&
            32'(band_r) < 32'(CELL_ROWS)) begin
          emit_band_nxt = band_r;
          idx_nxt       = '0;
          state_nxt     = ST_EMIT;
        end else if (done_nxt || rem_nxt == 8'd0) begin
          finish = 1'b1;
        end
      end
      ST_EMIT: begin
        if (capped || !out_valid_r || out_ready) begin
          if (!capped) begin
            load_out                  = 1'b1;
            sent_nxt                  = sent_r + 1'b1;
            out_data_nxt.density      = dens;
            out_data_nxt.char_code    = rbad_pkg::char_of(dens);
            out_data_nxt.cell_column  = idx_ext[5:0];
            out_data_nxt.cell_row     = band_ext[3:0];
            out_data_nxt.last_of_band = (idx_r == IDX_W'(CELL_COLUMNS - 1));
          end
          // shift the band out through cell 0, clearing behind it
          for (int k = 0; k < CELL_COLUMNS - 1; k++) begin
            counts_nxt[k] = counts_r[k + 1];
          end
          counts_nxt[CELL_COLUMNS - 1] = '0;
          if (idx_r == IDX_W'(CELL_COLUMNS - 1)) begin
            if (done_r || rem_r == 8'd0) begin
              finish = 1'b1;
            end else begin
              state_nxt = ST_RUN;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      colour_nxt = ~colour_r;
      state_nxt  = ST_IDLE;
    end

    out_valid_nxt = out_valid_r && !out_ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      sub_r       <= '0;
      band_r      <= '0;
      colour_r    <= 1'b0;
      done_r      <= 1'b0;
      rem_r       <= '0;
      idx_r       <= '0;
      emit_band_r <= '0;
      sent_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < CELL_COLUMNS; k++) begin
        counts_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      sub_r       <= sub_nxt;
      band_r      <= band_nxt;
      colour_r    <= colour_nxt;
      done_r      <= done_nxt;
      rem_r       <= rem_nxt;
      idx_r       <= idx_nxt;
      emit_band_r <= emit_band_nxt;
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < CELL_COLUMNS; k++) begin
        counts_r[k] <= counts_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// File: sv/rle_bilevel_to_ascii_density_top.sv
// top level of the run-length bilevel to ascii density block
// depends on rbad_pkg, rbad_front, rbad_back and the assertion macro header
//
// Decodes alternating black/white run lengths of a bilevel frame (row by row,
// FRAME_WIDTH pixels a row, every frame starting black, a zero run only
// flipping the colour, the run that reaches the frame end clipped there) and
// counts white pixels into CELL_WIDTH x CELL_HEIGHT cells. When the last row
// of one of the first CELL_ROWS bands completes, CELL_COLUMNS words leave on
// the out_ channel, one per cell: ramp character, density (count*9/12, max 9),
// cell column, band and a last-of-band flag. Runs after the frame end are
// dropped until a word with start_of_frame arrives. The front end queues up to
// two run words; the back end takes one word at a time in its idle state,
// then handles the row segments the run touches one at a time (up to 4 for a
// 255-pixel run at the default 120-pixel width), and for each band it
// completes shifts the band out one cell a cycle through the output register
// while out_ready allows. Zero runs and dropped runs are handled in the idle
// state alone and never leave it.

module rle_bilevel_to_ascii_density_top #(
  parameter int FRAME_WIDTH  = rbad_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rbad_pkg::FRAME_HEIGHT_DEF,
  parameter int CELL_WIDTH   = rbad_pkg::CELL_WIDTH_DEF,
  parameter int CELL_HEIGHT  = rbad_pkg::CELL_HEIGHT_DEF,
  parameter int CELL_COLUMNS = rbad_pkg::CELL_COLUMNS_DEF,
  parameter int CELL_ROWS    = rbad_pkg::CELL_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rbad_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rbad_pkg::out_word_t out_data
);

`include "rle_bilevel_to_ascii_density_top_assert.svh"

  // cell column code of the last cell, as it appears in the 6-bit field
  localparam logic [5:0] LAST_COL_CODE = 6'((CELL_COLUMNS - 1) % 64);

  // queue between front and back end
  logic           cmd_valid;
  logic           cmd_ready;
  rbad_pkg::cmd_t cmd;

  // front end: takes run words, flags zero runs, holds a short queue
  rbad_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // back end: row-segment expansion, cell counters, band shift-out
  rbad_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .CELL_WIDTH   (CELL_WIDTH),
    .CELL_HEIGHT  (CELL_HEIGHT),
    .CELL_COLUMNS (CELL_COLUMNS),
    .CELL_ROWS    (CELL_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // an empty queue always has room for a word
  `RBAD_ASSERT_IMPLIES(a_empty_queue_ready, clk, rst_n, !cmd_valid, in_ready)
  // the character always matches the reported density, which never exceeds 9
  `RBAD_ASSERT_IMPLIES(a_char_matches_density, clk, rst_n, out_valid,
    (out_data.density <= 4'd9) &&
    (out_data.char_code == rbad_pkg::char_of(out_data.density)))
  // the band marker sits on the last cell column only
  `RBAD_ASSERT_IMPLIES(a_last_on_last_column, clk, rst_n,
    out_valid && out_data.last_of_band, out_data.cell_column == LAST_COL_CODE)

endmodule

// File: test/tb.sv
// testbench for rle_bilevel_to_ascii_density_top: drives run-length words, predicts density words
// depends on rbad_pkg and the rle_bilevel_to_ascii_density_top rtl; self-checking, no files read
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // quiet cycles (no word moving on either side) before the run is declared hung
  localparam int IDLE_LIMIT  = 4000;
  // cycles to linger after the last expected word, about one band shift-out and then some
  localparam int TAIL_CYCLES = 80;
  // long receiver hold-off, well past the time the input queue needs to fill
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam int BAND_ROWS   = rbad_pkg::CELL_ROWS_DEF * rbad_pkg::CELL_HEIGHT_DEF;
  localparam int BAND_PIXELS = rbad_pkg::CELL_COLUMNS_DEF * rbad_pkg::CELL_WIDTH_DEF;

  // directed words as {run_length, start_of_frame}
  localparam logic [8:0] DIRECTED [22] = '{
    {8'd0,   1'b1},  // zero run right at frame start: black flips to white, no pixels
    {8'd255, 1'b0},  // longest white run, spans three row segments
    {8'd0,   1'b0},  // back-to-back zero runs
    {8'd0,   1'b0},
    {8'h55,  1'b0},
    {8'hAA,  1'b0},  // this one completes band 0
    {8'd1,   1'b0},
    {8'd2,   1'b0},
    {8'd3,   1'b0},
    {8'd12,  1'b0},
    {8'd6,   1'b0},
    {8'd9,   1'b0},
    {8'd4,   1'b0},
    {8'd7,   1'b0},
    {8'd127, 1'b0},
    {8'd128, 1'b0},
    {8'd254, 1'b0},
    {8'd255, 1'b1},  // resync mid frame with a full-length black run
    {8'd255, 1'b0},
    {8'd0,   1'b1},  // resync again, empty run
    {8'd240, 1'b0},
    {8'd255, 1'b0}
  };

  // predicts the character words of each completed band and checks the dut's words in order
  class density_scoreboard;
    int unsigned         px_col;
    int unsigned         px_row;
    bit                  white;
    bit                  done;
    int unsigned         cell_white [rbad_pkg::CELL_COLUMNS_DEF];
    rbad_pkg::out_word_t expected_chars [$];
    int unsigned         n_bad;
    string               ramp;

    function new();
      n_bad = 0;
      ramp  = " .:-=+*#%@";
      clear_frame();
    endfunction

    function void clear_frame();
      px_col = 0;
      px_row = 0;
      white  = 1'b0;
      done   = 1'b0;
      foreach (cell_white[i]) cell_white[i] = 0;
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    function void flag(string msg);
      n_bad++;
      if (n_bad <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // returns 1 when the word was decoded, 0 when dropped after the frame end
    function bit note_input(rbad_pkg::in_word_t w);
      rbad_pkg::out_word_t r;
      int unsigned         d;
      byte                 ch;
      if (w.start_of_frame) clear_frame();
      if (done) return 1'b0;
      for (int i = 0; i < int'(w.run_length); i++) begin
        if (white && px_row < BAND_ROWS && px_col < BAND_PIXELS) begin
          cell_white[px_col / rbad_pkg::CELL_WIDTH_DEF]++;
        end
        px_col++;
        if (px_col >= rbad_pkg::FRAME_WIDTH_DEF) begin
          px_col = 0;
          px_row++;
          if (px_row % rbad_pkg::CELL_HEIGHT_DEF == 0 && px_row <= BAND_ROWS) begin
            for (int c = 0; c < rbad_pkg::CELL_COLUMNS_DEF; c++) begin
              d = cell_white[c] * 9 / 12;
              if (d > 9) d = 9;
              ch             = ramp[d];
              r.char_code    = ch[6:0];
              r.density      = d[3:0];
              r.cell_column  = 6'(c);
              r.cell_row     = 4'(px_row / rbad_pkg::CELL_HEIGHT_DEF - 1);
              r.last_of_band = (c == rbad_pkg::CELL_COLUMNS_DEF - 1);
              expected_chars.push_back(r);
              cell_white[c] = 0;
            end
          end
          if (px_row >= rbad_pkg::FRAME_HEIGHT_DEF) begin
            done = 1'b1;
            break;
          end
        end
      end
      white = !white;
      return 1'b1;
    endfunction

    function void check_result(rbad_pkg::out_word_t got);
      rbad_pkg::out_word_t e;
      if (expected_chars.size() == 0) begin
        flag($sformatf("unexpected word: char %h dens %0d col %0d band %0d last %b",
                       got.char_code, got.density, got.cell_column, got.cell_row,
                       got.last_of_band));
        return;
      end
      e = expected_chars.pop_front();
      if (got.char_code !== e.char_code || got.density !== e.density ||
          got.cell_column !== e.cell_column || got.cell_row !== e.cell_row ||
          got.last_of_band !== e.last_of_band) begin
        flag($sformatf({"mismatch: expected char %h dens %0d col %0d band %0d last %b,",
                        " got char %h dens %0d col %0d band %0d last %b"},
                       e.char_code, e.density, e.cell_column, e.cell_row, e.last_of_band,
                       got.char_code, got.density, got.cell_column, got.cell_row,
                       got.last_of_band));
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  rbad_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  rbad_pkg::out_word_t out_data;

  // knobs shared by the driving processes
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_req;
  int          hold_left;
  int unsigned live_items;   // words actually decoded, dropped ones excluded
  int unsigned quiet;

  density_scoreboard sb = new();

  rle_bilevel_to_ascii_density_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // offer one run word, wait for the handshake, then maybe go idle for a while;
  // valid stays high when the next word follows right away
  task automatic send_word(input logic [7:0] len, input logic sof);
    rbad_pkg::in_word_t w;
    w.run_length     = len;
    w.start_of_frame = sof;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (sb.note_input(w)) live_items++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // sender steps back until every predicted word has come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // mostly whole frames with random runs, some abandoned, some resynced mid frame,
  // and a few stray runs after the frame end that the block must drop
  task automatic random_phase(input int budget, input int s_idle, input int r_stall,
                              input bit long_hold, input bit pause_mid);
    int          goal;
    int          mode;
    int          noise;
    bit          paused;
    logic [7:0]  len;
    hold_until_drained();
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    if (long_hold) hold_req = HOLD_CYCLES;
    goal   = live_items + budget;
    paused = !pause_mid;
    while (live_items < goal) begin
      // run length style per frame: wide random, mostly short for mid densities, always long
      mode = $urandom_range(2);
      send_word(8'($urandom_range(255)), 1'b1);
      while (!sb.done && live_items < goal) begin
        case (mode)
          0:       len = 8'($urandom_range(255));
          1:       len = ($urandom_range(9) < 7) ? 8'($urandom_range(12))
                                                 : 8'($urandom_range(255));
          default: len = 8'($urandom_range(255, 190));
        endcase
        send_word(len, $urandom_range(99) < 2);
        if (!paused && live_items >= goal - budget / 2) begin
          hold_until_drained();
          paused = 1'b1;
        end
        if ($urandom_range(199) == 0) break;  // broken frame, next one resyncs
      end
      noise = $urandom_range(3);
      repeat (noise) send_word(8'($urandom_range(255)), 1'b0);
    end
  endtask

  // receiver: check each word taken, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req  = 0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no word moving at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    hold_left      = 0;
    live_items     = 0;
    quiet          = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, zero runs, resyncs, a first band
    foreach (DIRECTED[i]) send_word(DIRECTED[i][8:1], DIRECTED[i][0]);

    // random phases: no idling, sender idle with a mid-phase drain,
    // receiver stalling with one long hold-off, both idling
    random_phase(95, 0, 0, 1'b0, 1'b0);
    random_phase(95, 46, 0, 1'b0, 1'b1);
    random_phase(95, 0, 46, 1'b1, 1'b0);
    random_phase(95, 32, 32, 1'b0, 1'b0);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.flag($sformatf("%0d expected words never arrived", sb.pending()));
    end
    if (sb.n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
